@@ src/agc_pkg.sv @@
// ----------------------------------------------------------------------------
// agc_pkg: shared definitions of the glyph compositor
// Item modes, register indexes, field widths, the control and status groups
// between controller and datapath, and the rounding divide by 255.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 10;
  localparam int COV_W   = 8;
  localparam int COLOR_W = 32;
  localparam int CHAN_W  = 8;
  localparam int RGB_W   = 3 * CHAN_W;
  localparam int PIX_W   = RGB_W + CHAN_W;
  localparam int ALPHA_W = 2 * CHAN_W;
  localparam int NUM_W   = 3 * CHAN_W;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FRAME_RESET      = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Quotient bits produced by the divider; one per cycle.
  localparam int DIV_STEPS = CHAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic accept;
    logic decode;
    logic clear_step;
    logic capture;
    logic mul;
    logic div_step;
    logic write;
    logic res_load;
  } agc_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              outside;
    logic              clear_empty;
    logic              clear_last;
    logic              outa_zero;
    logic              div_last;
  } agc_stat_t;

  // Rounding divide by 255 in shift-add form, valid for x up to 255 * 255.
  function automatic logic [CHAN_W-1:0] div255(input logic [ALPHA_W-1:0] x);
    logic [ALPHA_W:0]   d1;
    logic [ALPHA_W:0]   s;
    logic [ALPHA_W+1:0] d2;
    d1 = (17'(x) + 17'd128) >> 8;
    s  = 17'(x) + d1;
    d2 = (18'(s) + 18'd128) >> 8;
    return d2[CHAN_W-1:0];
  endfunction

endpackage

@@ src/agc_if.sv @@
// ----------------------------------------------------------------------------
// agc_if: channel interfaces of the glyph compositor
// Item, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface agc_item_if import agc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [COV_W-1:0]   coverage;
  logic [COLOR_W-1:0] color;

  modport source (output valid, mode, pos_x, pos_y, coverage, color, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, coverage, color, output ready);
endinterface

interface agc_result_if import agc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] pixel_alpha;
  logic              outside;

  modport source (output valid, red, green, blue, pixel_alpha, outside, input ready);
  modport sink   (input valid, red, green, blue, pixel_alpha, outside, output ready);
endinterface

interface agc_cfg_if import agc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/agc_ram.sv @@
// ----------------------------------------------------------------------------
// agc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module agc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/agc_ctrl.sv @@
// ----------------------------------------------------------------------------
// agc_ctrl: controller of the glyph compositor
// Sequences clear sweeps, store reads, the blend arithmetic and the divider,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module agc_ctrl import agc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  agc_stat_t stat,
  output agc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_WRITE  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.mode == MODE_CLEAR) begin
          state_next = stat.clear_empty ? ST_DONE : ST_CLEAR;
        end else if (stat.mode == MODE_NONE || stat.outside) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FETCH: begin
        cmd.capture = 1'b1;
        state_next  = (stat.mode == MODE_BLEND) ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = stat.outa_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result register must be empty or emptying before it is reloaded.
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/agc_dp.sv @@
// ----------------------------------------------------------------------------
// agc_dp: datapath of the glyph compositor
// Frame size registers, item registers, clear address walk, blend products,
// three restoring dividers sharing one divisor, and the result register.
// ----------------------------------------------------------------------------
module agc_dp import agc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  agc_cmd_t              cmd,
  output agc_stat_t             stat,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [MODE_W-1:0]     mode,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [COV_W-1:0]      coverage,
  input  logic [COLOR_W-1:0]    color,
  output logic [CHAN_W-1:0]     red,
  output logic [CHAN_W-1:0]     green,
  output logic [CHAN_W-1:0]     blue,
  output logic [CHAN_W-1:0]     pixel_alpha,
  output logic                  outside,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [PIX_W-1:0]      ram_wdata,
  output logic [AW-1:0]         ram_raddr,
  input  logic [PIX_W-1:0]      ram_rdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;

  logic [MODE_W-1:0] item_mode;
  logic [COV_W-1:0]  item_cov;
  logic [RGB_W-1:0]  item_src;
  logic [CHAN_W-1:0] item_inv_alpha;
  logic [AW-1:0]     item_addr;
  logic              item_outside;

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [AW-1:0] caddr;
  logic [AW-1:0] row_base;

  logic [CHAN_W-1:0]  k;
  logic [RGB_W-1:0]   pix_rgb;
  logic [CHAN_W-1:0]  pix_a;
  logic [ALPHA_W-1:0] outa;
  logic [ALPHA_W-1:0] kx;
  logic [CHAN_W-1:0]  nk;
  logic [ALPHA_W-1:0] dd  [3];
  logic [ALPHA_W-1:0] rem [3];
  logic [CHAN_W-1:0]  low [3];
  logic [DIV_CNT_W-1:0] div_cnt;

  logic              in_out;
  logic              x_last;
  logic              y_last;
  logic [ALPHA_W-1:0] kx_comb;
  logic [CHAN_W-1:0]  src_alpha;
  logic [CHAN_W-1:0]  nk_comb;
  logic [ALPHA_W:0]   shifted [3];
  logic [ALPHA_W:0]   diff    [3];
  logic               qbit    [3];
  logic [NUM_W-1:0]   num     [3];
  logic [CHAN_W-1:0]  new_alpha;

  // Bounds against the smaller of the register and the store dimension.
  assign in_out = (32'(pos_x) >= 32'(frame_width)) || (32'(pos_x) >= 32'(MAX_WIDTH)) ||
                  (32'(pos_y) >= 32'(frame_height)) || (32'(pos_y) >= 32'(MAX_HEIGHT));

  assign x_last = (32'(cx) + 32'd1 >= 32'(frame_width)) ||
                  (32'(cx) + 32'd1 >= 32'(MAX_WIDTH));
  assign y_last = (32'(cy) + 32'd1 >= 32'(frame_height)) ||
                  (32'(cy) + 32'd1 >= 32'(MAX_HEIGHT));

  // Source alpha is the inverse of the color's low byte.
  assign src_alpha = ~item_inv_alpha;
  assign nk_comb   = ~k;
  assign kx_comb   = {k, 8'd0} - ALPHA_W'(k);
  assign new_alpha = div255(outa);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'(kx) * NUM_W'(item_src[RGB_W-1-CHAN_W*i -: CHAN_W]) +
               NUM_W'(dd[i]) * NUM_W'(nk);
      shifted[i] = {rem[i], low[i][CHAN_W-1]};
      diff[i]    = shifted[i] - {1'b0, outa};
      qbit[i]    = (shifted[i] >= {1'b0, outa});
    end
  end

  always_comb begin
    stat.mode        = item_mode;
    stat.outside     = item_outside;
    stat.clear_empty = (frame_width == '0) || (frame_height == '0);
    stat.clear_last  = x_last && y_last;
    stat.outa_zero   = (outa == '0);
    stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  end

  assign ram_we    = cmd.write || cmd.clear_step;
  assign ram_waddr = cmd.clear_step ? caddr : item_addr;
  assign ram_wdata = cmd.write ? {low[0], low[1], low[2], new_alpha} : '0;
  assign ram_raddr = item_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode      <= mode;
      item_cov       <= coverage;
      item_src       <= color[COLOR_W-1:CHAN_W];
      item_inv_alpha <= color[CHAN_W-1:0];
      item_addr      <= AW'(32'(pos_y) * 32'(MAX_WIDTH) + 32'(pos_x));
      item_outside   <= (mode == MODE_BLEND || mode == MODE_READ) && in_out;
      cx             <= '0;
      cy             <= '0;
      caddr          <= '0;
      row_base       <= '0;
    end
    if (cmd.clear_step) begin
      if (x_last) begin
        cx       <= '0;
        cy       <= cy + 1'b1;
        row_base <= row_base + AW'(MAX_WIDTH);
        caddr    <= row_base + AW'(MAX_WIDTH);
      end else begin
        cx    <= cx + 1'b1;
        caddr <= caddr + 1'b1;
      end
    end
    if (cmd.decode) begin
      k <= div255(ALPHA_W'(item_cov) * ALPHA_W'(src_alpha));
    end
    if (cmd.capture) begin
      pix_rgb <= ram_rdata[PIX_W-1:CHAN_W];
      pix_a   <= ram_rdata[CHAN_W-1:0];
      kx      <= kx_comb;
      nk      <= nk_comb;
      outa    <= kx_comb + ALPHA_W'(ram_rdata[CHAN_W-1:0]) * ALPHA_W'(nk_comb);
      for (int i = 0; i < 3; i++) begin
        dd[i] <= ALPHA_W'(ram_rdata[PIX_W-1-CHAN_W*i -: CHAN_W]) *
                 ALPHA_W'(ram_rdata[CHAN_W-1:0]);
      end
    end
    if (cmd.mul) begin
      // The quotient fits in a byte, so the upper bits start below the divisor.
      for (int i = 0; i < 3; i++) begin
        rem[i] <= num[i][NUM_W-1:CHAN_W];
        low[i] <= num[i][CHAN_W-1:0];
      end
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= qbit[i] ? diff[i][ALPHA_W-1:0] : shifted[i][ALPHA_W-1:0];
        low[i] <= {low[i][CHAN_W-2:0], qbit[i]};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.write) begin
      pix_rgb <= {low[0], low[1], low[2]};
      pix_a   <= new_alpha;
    end
    if (cmd.res_load) begin
      if ((item_mode == MODE_BLEND || item_mode == MODE_READ) && !item_outside) begin
        red         <= pix_rgb[RGB_W-1 -: CHAN_W];
        green       <= pix_rgb[RGB_W-1-CHAN_W -: CHAN_W];
        blue        <= pix_rgb[CHAN_W-1:0];
        pixel_alpha <= pix_a;
      end else begin
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        pixel_alpha <= '0;
      end
      outside <= item_outside;
    end
  end

endmodule

@@ src/alpha_glyph_compositor.sv @@
// ----------------------------------------------------------------------------
// alpha_glyph_compositor: overlay compositor with an RGB and alpha frame store
// Blends glyph coverage samples over stored pixels, clears and reads the store.
// ----------------------------------------------------------------------------
// Blend: decode, fetch, multiply, divide (one quotient bit a cycle) and write;
//   the divide and the write are skipped when the combined alpha is zero.
// Read: decode and fetch. Clear: one store entry written per cycle.
// Outside or unused mode: decode only. One word is in work at a time; a finished
//   result waits in the output register while the next word is taken.
// Reset sets both frame size registers to 1024; the store is not initialized.
module alpha_glyph_compositor import agc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic          clk,
  input logic          rst,
  agc_cfg_if.sink      cfg,
  agc_item_if.sink     items,
  agc_result_if.source results
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  agc_cmd_t         cmd;
  agc_stat_t        stat;
  logic             cfg_we;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  agc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg.addr),
    .cfg_data    (cfg.data),
    .mode        (items.mode),
    .pos_x       (items.pos_x),
    .pos_y       (items.pos_y),
    .coverage    (items.coverage),
    .color       (items.color),
    .red         (results.red),
    .green       (results.green),
    .blue        (results.blue),
    .pixel_alpha (results.pixel_alpha),
    .outside     (results.outside),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  agc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An outside position never reports pixel data.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.outside |->
      results.red == '0 && results.green == '0 &&
      results.blue == '0 && results.pixel_alpha == '0)
    else $error("outside result carries pixel data");

  // Only one word is in work: input closes right after a word is taken.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("second word accepted while one is in work");

  // The store is only written while a word is in work.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !items.ready)
    else $error("store written while idle");

  // A loaded result register presents its word in the next cycle.
  a_load_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> results.valid)
    else $error("result register loaded without valid");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for alpha_glyph_compositor
// A short table of directed words with hand-computed answers where they are
// obvious, then random blend, read, clear and unused-mode words over several
// frame sizes and handshake idling profiles. A local over-operator model with
// its own frame store predicts every result word that has no hand-computed answer.
// ----------------------------------------------------------------------------
module testbench;
  import agc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned STORE_PITCH  = DEF_MAX_WIDTH;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned PHASE_WORDS  = 290;
  localparam int unsigned NUM_PHASES   = 6;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COV_W-1:0]   coverage;
    logic [COLOR_W-1:0] color;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] pixel_alpha;
    logic              outside;
  } pixel_t;

  typedef enum int {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] reg_addr;
    int unsigned           reg_value;
    sample_t               sample;
    bit                    typed;
    pixel_t                want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  agc_cfg_if    cfg_ch ();
  agc_item_if   items_ch ();
  agc_result_if results_ch ();

  alpha_glyph_compositor dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the frame store and size registers.
  logic [RGB_W-1:0]  stored_rgb   [int unsigned];
  logic [CHAN_W-1:0] stored_alpha [int unsigned];
  int unsigned frame_w = 1024;
  int unsigned frame_h = 1024;

  pixel_t      due_pixels [$];
  int unsigned mismatches  = 0;
  int unsigned pixels_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_left   = 0;
  int          hold_mark   = -1;

  // Recently used position, so that blends pile up on the same pixel.
  bit               have_spot = 1'b0;
  logic [POS_W-1:0] spot_x;
  logic [POS_W-1:0] spot_y;

  row_t directed [$];

  function automatic int unsigned scale255(int unsigned x);
    int unsigned q;
    q = (x + 128) >> 8;
    return (x + q + 128) >> 8;
  endfunction

  function automatic logic [CHAN_W-1:0] over_chan(int unsigned k, int unsigned src,
                                                  int unsigned dst, int unsigned da,
                                                  int unsigned outa);
    int unsigned num;
    num = k * 255 * src + dst * da * (255 - k);
    return CHAN_W'(num / outa);
  endfunction

  function automatic int unsigned active_w();
    return (frame_w < DEF_MAX_WIDTH) ? frame_w : DEF_MAX_WIDTH;
  endfunction

  function automatic int unsigned active_h();
    return (frame_h < DEF_MAX_HEIGHT) ? frame_h : DEF_MAX_HEIGHT;
  endfunction

  // Applies one sample to the local store and returns the pixel it yields.
  function automatic pixel_t composite(sample_t s);
    pixel_t           p;
    int unsigned      wa, ha, idx, da, sa, k, outa;
    logic [RGB_W-1:0] rgb;
    p  = '0;
    wa = active_w();
    ha = active_h();
    if (s.mode == MODE_CLEAR) begin
      for (int unsigned y = 0; y < ha; y++) begin
        for (int unsigned x = 0; x < wa; x++) begin
          stored_rgb[y * STORE_PITCH + x]   = '0;
          stored_alpha[y * STORE_PITCH + x] = '0;
        end
      end
    end else if (s.mode != MODE_NONE) begin
      if (s.pos_x >= wa || s.pos_y >= ha) begin
        p.outside = 1'b1;
      end else begin
        idx = s.pos_y * STORE_PITCH + s.pos_x;
        rgb = stored_rgb.exists(idx) ? stored_rgb[idx] : '0;
        da  = stored_alpha.exists(idx) ? stored_alpha[idx] : 0;
        if (s.mode == MODE_BLEND) begin
          sa   = 255 - s.color[7:0];
          k    = scale255(s.coverage * sa);
          outa = k * 255 + da * (255 - k);
          // A fully transparent result leaves the pixel as it was.
          if (outa != 0) begin
            rgb = {over_chan(k, s.color[31:24], rgb[23:16], da, outa),
                   over_chan(k, s.color[23:16], rgb[15:8], da, outa),
                   over_chan(k, s.color[15:8], rgb[7:0], da, outa)};
            da  = scale255(outa) & 255;
            stored_rgb[idx]   = rgb;
            stored_alpha[idx] = CHAN_W'(da);
          end
        end
        p.red         = rgb[23:16];
        p.green       = rgb[15:8];
        p.blue        = rgb[7:0];
        p.pixel_alpha = CHAN_W'(da);
      end
    end
    return p;
  endfunction

  function automatic pixel_t px(int unsigned r, int unsigned g, int unsigned b,
                                int unsigned a, bit o);
    pixel_t p;
    p = '{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b), CHAN_W'(a), o};
    return p;
  endfunction

  function automatic row_t reg_row(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
    row_t r;
    r = '{ROW_REG, addr, value, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t sample_row(logic [MODE_W-1:0] mode, int unsigned x,
                                      int unsigned y, int unsigned cov,
                                      logic [COLOR_W-1:0] color, bit typed, pixel_t want);
    row_t r;
    r = '{ROW_SAMPLE, '0, 0, '{mode, POS_W'(x), POS_W'(y), COV_W'(cov), color}, typed, want};
    return r;
  endfunction

  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    s.coverage = COV_W'($urandom);
    s.color    = $urandom;
    s.pos_x    = POS_W'($urandom);
    s.pos_y    = POS_W'($urandom);
    case ($urandom_range(7))
      0: s.coverage = '0;
      1: s.coverage = '1;
      2: s.color[7:0] = '0;
      3: s.color[7:0] = '1;
      default: ;
    endcase
    pick = $urandom_range(999);
    if (pick < 8) begin
      s.mode = MODE_CLEAR;
    end else if (pick < 30) begin
      s.mode = MODE_NONE;
    end else begin
      s.mode = (pick < 700) ? MODE_BLEND : MODE_READ;
      // One in ten keeps its raw random position, which mostly lands outside.
      if (pick % 10 != 0) begin
        if (have_spot && $urandom_range(2) == 0) begin
          s.pos_x = spot_x;
          s.pos_y = spot_y;
        end else begin
          s.pos_x = POS_W'($urandom_range(active_w() - 1));
          s.pos_y = POS_W'($urandom_range(active_h() - 1));
        end
        spot_x    = s.pos_x;
        spot_y    = s.pos_y;
        have_spot = 1'b1;
      end
    end
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = addr;
    cfg_ch.data  = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    if (addr == REG_FRAME_WIDTH) frame_w = value & 32'h7FF;
    else frame_h = value & 32'h7FF;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_sample(sample_t s, bit typed, pixel_t want);
    pixel_t got;
    while ($urandom_range(99) < idle_pct) begin
      items_ch.valid = 1'b0;
      @(negedge clk);
    end
    items_ch.valid    = 1'b1;
    items_ch.mode     = s.mode;
    items_ch.pos_x    = s.pos_x;
    items_ch.pos_y    = s.pos_y;
    items_ch.coverage = s.coverage;
    items_ch.color    = s.color;
    do @(posedge clk); while (!items_ch.ready);
    got = composite(s);
    due_pixels.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    items_ch.valid = 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off per marked phase.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      results_ch.ready = 1'b0;
    end else if (hold_mark >= 0 && pixels_seen == hold_mark) begin
      hold_mark        = -1;
      hold_left        = HOLD_CYCLES;
      results_ch.ready = 1'b0;
    end else begin
      results_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end else if (!rst && results_ch.valid && results_ch.ready) begin
      got = '{results_ch.red, results_ch.green, results_ch.blue,
              results_ch.pixel_alpha, results_ch.outside};
      pixels_seen++;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d arrived with nothing pending: %p", pixels_seen, got);
      end else begin
        want = due_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.pixel_alpha !== want.pixel_alpha ||
            got.outside !== want.outside) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word %0d: expected r=%h g=%h b=%h a=%h out=%b, got r=%h g=%h b=%h a=%h out=%b",
                     pixels_seen, want.red, want.green, want.blue, want.pixel_alpha,
                     want.outside, got.red, got.green, got.blue, got.pixel_alpha,
                     got.outside);
        end
      end
    end
  end

  initial begin
    int unsigned phase_w     [NUM_PHASES] = '{16, 1024, 1, 37, 2047, 5};
    int unsigned phase_h     [NUM_PHASES] = '{16, 1, 1024, 29, 3, 2047};
    int unsigned phase_idle  [NUM_PHASES] = '{0, 49, 0, 20, 0, 49};
    int unsigned phase_stall [NUM_PHASES] = '{0, 0, 49, 20, 0, 0};
    sample_t     wipe;
    pixel_t      blank;

    rst                 = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = '0;
    cfg_ch.data         = '0;
    items_ch.valid      = 1'b0;
    items_ch.mode       = '0;
    items_ch.pos_x      = '0;
    items_ch.pos_y      = '0;
    items_ch.coverage   = '0;
    items_ch.color      = '0;
    results_ch.ready    = 1'b0;
    blank               = '0;
    wipe                = '{MODE_CLEAR, '0, '0, '0, '0};

    // Reset sizes are checked by clearing one line or one column and then
    // reading its far end.
    directed.push_back(sample_row(MODE_NONE, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(reg_row(REG_FRAME_HEIGHT, 1));
    directed.push_back(sample_row(MODE_CLEAR, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_READ, 1023, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_READ, 0, 1, 0, 32'h0, 1, px(0, 0, 0, 0, 1)));
    directed.push_back(reg_row(REG_FRAME_WIDTH, 1));
    directed.push_back(reg_row(REG_FRAME_HEIGHT, 2047));
    directed.push_back(sample_row(MODE_CLEAR, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_READ, 0, 1023, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_BLEND, 1, 0, 255, 32'hFFFFFF00, 1, px(0, 0, 0, 0, 1)));
    directed.push_back(reg_row(REG_FRAME_WIDTH, 16));
    directed.push_back(reg_row(REG_FRAME_HEIGHT, 16));
    directed.push_back(sample_row(MODE_CLEAR, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_BLEND, 3, 4, 255, 32'hFF804000, 1,
                                  px(8'hFF, 8'h80, 8'h40, 8'hFF, 0)));
    directed.push_back(sample_row(MODE_BLEND, 3, 4, 0, 32'h0, 0, blank));
    // Zero combined alpha: no coverage, and then no source alpha.
    directed.push_back(sample_row(MODE_BLEND, 5, 5, 0, 32'h12345600, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_BLEND, 5, 5, 255, 32'hABCDEFFF, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_BLEND, 6, 6, 128, 32'h12345680, 0, blank));
    directed.push_back(sample_row(MODE_READ, 6, 6, 0, 32'h0, 0, blank));
    directed.push_back(sample_row(MODE_BLEND, 15, 15, 255, 32'hFFFFFF00, 1,
                                  px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0)));
    directed.push_back(sample_row(MODE_BLEND, 15, 15, 1, 32'h0, 0, blank));
    directed.push_back(sample_row(MODE_BLEND, 16, 0, 255, 32'hFFFFFF00, 1, px(0, 0, 0, 0, 1)));
    directed.push_back(sample_row(MODE_READ, 0, 16, 0, 32'h0, 1, px(0, 0, 0, 0, 1)));
    directed.push_back(sample_row(MODE_READ, 1023, 1023, 0, 32'h0, 1, px(0, 0, 0, 0, 1)));
    directed.push_back(sample_row(MODE_NONE, 1023, 1023, 255, 32'hFFFFFFFF, 1,
                                  px(0, 0, 0, 0, 0)));
    // A zero width puts every position outside and makes a clear a no-op.
    directed.push_back(reg_row(REG_FRAME_WIDTH, 0));
    directed.push_back(sample_row(MODE_CLEAR, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 0)));
    directed.push_back(sample_row(MODE_READ, 0, 0, 0, 32'h0, 1, px(0, 0, 0, 0, 1)));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed[i].reg_addr, directed[i].reg_value);
      end else begin
        send_sample(directed[i].sample, directed[i].typed, directed[i].want);
      end
    end

    // Each phase starts with a clear so that every in-frame entry is defined.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(REG_FRAME_WIDTH, phase_w[p]);
      write_reg(REG_FRAME_HEIGHT, phase_h[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      have_spot = 1'b0;
      if (p == 0 || p == 3) hold_mark = pixels_seen + 40;
      send_sample(wipe, 1'b0, blank);
      for (int unsigned n = 0; n < PHASE_WORDS; n++)
        send_sample(random_sample(), 1'b0, blank);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && due_pixels.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

@@ alpha_glyph_compositor.f @@
src/agc_pkg.sv
src/agc_if.sv
src/agc_ram.sv
src/agc_ctrl.sv
src/agc_dp.sv
src/alpha_glyph_compositor.sv
tb/testbench.sv
